[rtl/nug_pkg.sv]
// shared types, constants and register codes of the nlms update gain unit
package nug_pkg;

  // field widths
  localparam int unsigned PowW     = 32;
  localparam int unsigned ErrW     = 32;
  localparam int unsigned GainW    = 32;
  localparam int unsigned RateW    = 16;
  localparam int unsigned PartW    = 7;
  localparam int unsigned CntW     = 8;
  localparam int unsigned ProdW    = RateW + ErrW;
  localparam int unsigned QuotW    = GainW - 1;
  localparam int unsigned DivCntW  = $clog2(QuotW + 1);
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  // partitions beyond this are used as this
  localparam logic [PartW-1:0] MAX_PARTITIONS = 7'd64;

  // reset values of the registers
  localparam logic [RateW-1:0] STEP_RATE_RST  = '0;
  localparam logic [PowW-1:0]  NOISE_GATE_RST = '0;
  localparam logic [PartW-1:0] PARTITIONS_RST = 7'd12;

  // saturation limits
  localparam logic [GainW-1:0] GAIN_POS_MAX = {1'b0, {(GainW-1){1'b1}}};
  localparam logic [GainW-1:0] GAIN_NEG_MIN = {1'b1, {(GainW-1){1'b0}}};

  // register word index (byte address / 4)
  typedef enum logic [1:0] {
    REG_STEP_RATE  = 2'd0,
    REG_NOISE_GATE = 2'd1,
    REG_PARTITIONS = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [RateW-1:0] step_rate;
    logic [PowW-1:0]  noise_gate;
    logic [PartW-1:0] part_eff;
  } cfg_t;

  // frame flags carried on the first bin
  typedef struct packed {
    logic first_bin;
    logic path_changed;
    logic poor_excitation;
    logic capture_saturated;
  } frame_flags_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QuotW-1:0] quot;
  } div_res_t;

endpackage

[rtl/nug_cfg_regs.sv]
// configuration register file behind the apb-style port
module nug_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nug_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [nug_pkg::DataW-1:0]   cfg_pwdata,
  output logic [nug_pkg::DataW-1:0]   cfg_prdata,
  output nug_pkg::cfg_t               cfg
);

  logic [nug_pkg::RateW-1:0] step_rate_r;
  logic [nug_pkg::PowW-1:0]  noise_gate_r;
  logic [nug_pkg::PartW-1:0] partitions_r;
  nug_pkg::reg_idx_t         reg_idx;
  logic                      wr_en;

  assign reg_idx = nug_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en   = cfg_psel & cfg_penable & cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_rate_r  <= nug_pkg::STEP_RATE_RST;
      noise_gate_r <= nug_pkg::NOISE_GATE_RST;
      partitions_r <= nug_pkg::PARTITIONS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        nug_pkg::REG_STEP_RATE:  step_rate_r  <= cfg_pwdata[nug_pkg::RateW-1:0];
        nug_pkg::REG_NOISE_GATE: noise_gate_r <= cfg_pwdata[nug_pkg::PowW-1:0];
        nug_pkg::REG_PARTITIONS: partitions_r <= cfg_pwdata[nug_pkg::PartW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      nug_pkg::REG_STEP_RATE:
        cfg_prdata = {{(nug_pkg::DataW-nug_pkg::RateW){1'b0}}, step_rate_r};
      nug_pkg::REG_NOISE_GATE:
        cfg_prdata = noise_gate_r;
      nug_pkg::REG_PARTITIONS:
        cfg_prdata = {{(nug_pkg::DataW-nug_pkg::PartW){1'b0}}, partitions_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  // partitions clamp to the supported maximum
  always_comb begin
    cfg.step_rate  = step_rate_r;
    cfg.noise_gate = noise_gate_r;
    cfg.part_eff   = (partitions_r > nug_pkg::MAX_PARTITIONS) ?
                     nug_pkg::MAX_PARTITIONS : partitions_r;
  end

endmodule

[rtl/nug_frame_ctl.sv]
// frame counters and adaptation enable decision
module nug_frame_ctl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_acc,
  input  nug_pkg::frame_flags_t       flags,
  input  logic [nug_pkg::PartW-1:0]   part_eff,
  output logic                        adapt_en
);

  logic [nug_pkg::CntW-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [nug_pkg::CntW-1:0] exc_cnt_r, exc_cnt_nxt;
  logic                     adapt_en_r, adapt_en_nxt;
  logic [nug_pkg::CntW-1:0] fc_base, ec_base, part_ext;

  assign part_ext = {{(nug_pkg::CntW-nug_pkg::PartW){1'b0}}, part_eff};

  // counter update on a first bin, saturating at all ones
  always_comb begin
    fc_base       = flags.path_changed ? '0 : frame_cnt_r;
    ec_base       = (flags.path_changed | flags.poor_excitation) ? '0 : exc_cnt_r;
    frame_cnt_nxt = (&fc_base) ? fc_base : fc_base + 1'b1;
    exc_cnt_nxt   = (&ec_base) ? ec_base : ec_base + 1'b1;
    adapt_en_nxt  = (exc_cnt_nxt >= part_ext) && (frame_cnt_nxt > part_ext) &&
                    !flags.capture_saturated;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      exc_cnt_r   <= '0;
      adapt_en_r  <= 1'b0;
    end else if (item_acc && flags.first_bin) begin
      frame_cnt_r <= frame_cnt_nxt;
      exc_cnt_r   <= exc_cnt_nxt;
      adapt_en_r  <= adapt_en_nxt;
    end
  end

  // enable that applies to the bin being taken
  assign adapt_en = flags.first_bin ? adapt_en_nxt : adapt_en_r;

endmodule

[rtl/nug_div.sv]
// shared restoring divider, one quotient bit per cycle, with up-front overflow check
module nug_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nug_pkg::ProdW-1:0]   dividend,
  input  logic [nug_pkg::PowW-1:0]    divisor,
  output nug_pkg::div_res_t           res
);

  localparam int unsigned HiW = nug_pkg::ProdW - nug_pkg::QuotW;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [nug_pkg::DivCntW-1:0]   cnt_r, cnt_nxt;
  logic [nug_pkg::PowW-1:0]      rem_r, rem_nxt;
  logic [nug_pkg::PowW-1:0]      dsr_r, dsr_nxt;
  logic [nug_pkg::QuotW-1:0]     low_r, low_nxt;
  logic [nug_pkg::QuotW-1:0]     quot_r, quot_nxt;
  logic [nug_pkg::PowW:0]        trial, diff;
  logic                          ge;
  logic                          hi_ovf;

  // quotient does not fit below the sign bit when the top part already reaches the divisor
  assign hi_ovf = {{(nug_pkg::PowW-HiW){1'b0}}, dividend[nug_pkg::ProdW-1:nug_pkg::QuotW]}
                  >= divisor;

  assign trial = {rem_r, low_r[nug_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  // start, then one compare and subtract per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    if (start) begin
      dsr_nxt  = divisor;
      ovf_nxt  = hi_ovf;
      quot_nxt = '0;
      rem_nxt  = {{(nug_pkg::PowW-HiW){1'b0}}, dividend[nug_pkg::ProdW-1:nug_pkg::QuotW]};
      low_nxt  = dividend[nug_pkg::QuotW-1:0];
      cnt_nxt  = nug_pkg::DivCntW'(nug_pkg::QuotW);
      busy_nxt = !hi_ovf;
      done_nxt = hi_ovf;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[nug_pkg::PowW-1:0] : trial[nug_pkg::PowW-1:0];
      quot_nxt = {quot_r[nug_pkg::QuotW-2:0], ge};
      low_nxt  = {low_r[nug_pkg::QuotW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == nug_pkg::DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    ovf_r  <= ovf_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

  // partial remainder always stays below the divisor
  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

endmodule

[rtl/nug_top_dummy_placeholder_never_used.sv]
// sequencer helper: saturates a divider result into a signed gain word
module nug_gain_sat (
  input  logic                        neg,
  input  nug_pkg::div_res_t           res,
  output logic [nug_pkg::GainW-1:0]   gain
);

  logic [nug_pkg::GainW-1:0] q_ext;

  assign q_ext = {1'b0, res.quot};

  // clamp on overflow, otherwise apply the sign of the error
  always_comb begin
    if (res.ovf) begin
      gain = neg ? nug_pkg::GAIN_NEG_MIN : nug_pkg::GAIN_POS_MAX;
    end else begin
      gain = neg ? (nug_pkg::GainW'(0) - q_ext) : q_ext;
    end
  end

endmodule

[rtl/nlms_update_gain_unit.sv]
// Update gain of a frequency-domain NLMS filter: one transaction in is one bin, one transaction
// out is its gain = step_rate * error / bin power per component (Q16.16, truncated toward
// zero, saturated to 32 bits), or zero when adaptation is off, the bin is band masked or the
// bin power is not above noise_gate. Frame flags on the first bin update the frame and
// excitation counters that decide adaptation. A bin with zero gain goes straight from accept to
// the output state and on into the output register. A bin with a computed gain passes, for each
// component, through a 16x32 multiply and then the single shared restoring divider, which runs
// twice (real then imaginary) at one quotient bit per cycle; a component whose quotient overflows
// skips the 31 divide steps.
// in_tready is high only between items; a finished result waits in the output register while
// the next bin is accepted, and a bin whose result finds that register still full waits.
module nlms_update_gain_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input bins
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,  // bin_power, error_re, error_im
  input  logic [4:0]                  in_tuser,  // band_masked, poor_excitation,
                                                 // capture_saturated, path_changed, first_bin
  input  logic                        in_tlast,  // last_bin
  // gain results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata, // gain_re, gain_im
  output logic                        out_tlast, // frame_end
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [nug_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [nug_pkg::DataW-1:0]   cfg_pwdata,
  output logic [nug_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  nug_pkg::cfg_t          cfg;
  nug_pkg::frame_flags_t  flags;
  nug_pkg::div_res_t      div_res;
  nug_pkg::state_t        state_r, state_nxt;

  logic [nug_pkg::PowW-1:0]  in_power;
  logic [nug_pkg::ErrW-1:0]  in_err_re, in_err_im;
  logic                      in_masked;
  logic                      in_acc;
  logic                      adapt_en;
  logic                      item_en;

  logic [nug_pkg::PowW-1:0]  power_r, power_nxt;
  logic [nug_pkg::ErrW-1:0]  err_re_r, err_re_nxt;
  logic [nug_pkg::ErrW-1:0]  err_im_r, err_im_nxt;
  logic                      last_r, last_nxt;
  logic                      comp_r, comp_nxt;
  logic                      neg_r, neg_nxt;
  logic [nug_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic [nug_pkg::GainW-1:0] gain_re_r, gain_re_nxt;
  logic [nug_pkg::GainW-1:0] gain_im_r, gain_im_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [63:0]               out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [nug_pkg::ErrW-1:0]  err_sel;
  logic [nug_pkg::ErrW-1:0]  mag;
  logic [nug_pkg::GainW-1:0] gain_sat;
  logic                      div_start;

  // unpack the input transaction
  assign in_power  = in_tdata[31:0];
  assign in_err_re = in_tdata[63:32];
  assign in_err_im = in_tdata[95:64];
  assign in_masked = in_tuser[0];
  assign flags.poor_excitation   = in_tuser[1];
  assign flags.capture_saturated = in_tuser[2];
  assign flags.path_changed      = in_tuser[3];
  assign flags.first_bin         = in_tuser[4];

  assign in_tready  = (state_r == nug_pkg::ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;

  nug_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg         (cfg)
  );

  nug_frame_ctl u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (in_acc),
    .flags    (flags),
    .part_eff (cfg.part_eff),
    .adapt_en (adapt_en)
  );

  nug_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (power_r),
    .res      (div_res)
  );

  nug_gain_sat u_sat (
    .neg  (neg_r),
    .res  (div_res),
    .gain (gain_sat)
  );

  assign item_en = adapt_en && !in_masked && (in_power > cfg.noise_gate);

  // magnitude of the error component in work
  assign err_sel = comp_r ? err_im_r : err_re_r;
  assign mag     = err_sel[nug_pkg::ErrW-1] ? (nug_pkg::ErrW'(0) - err_sel) : err_sel;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    power_nxt     = power_r;
    err_re_nxt    = err_re_r;
    err_im_nxt    = err_im_r;
    last_nxt      = last_r;
    comp_nxt      = comp_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    gain_re_nxt   = gain_re_r;
    gain_im_nxt   = gain_im_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    case (state_r)
      nug_pkg::ST_IDLE: begin
        if (in_acc) begin
          power_nxt  = in_power;
          err_re_nxt = in_err_re;
          err_im_nxt = in_err_im;
          last_nxt   = in_tlast;
          comp_nxt   = 1'b0;
          if (item_en) begin
            state_nxt = nug_pkg::ST_MUL;
          end else begin
            gain_re_nxt = '0;
            gain_im_nxt = '0;
            state_nxt   = nug_pkg::ST_OUT;
          end
        end
      end
      nug_pkg::ST_MUL: begin
        prod_nxt  = cfg.step_rate * mag;
        neg_nxt   = err_sel[nug_pkg::ErrW-1];
        state_nxt = nug_pkg::ST_DIV_START;
      end
      nug_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = nug_pkg::ST_DIV_WAIT;
      end
      nug_pkg::ST_DIV_WAIT: begin
        if (div_res.done) begin
          if (!comp_r) begin
            gain_re_nxt = gain_sat;
            comp_nxt    = 1'b1;
            state_nxt   = nug_pkg::ST_MUL;
          end else begin
            gain_im_nxt = gain_sat;
            state_nxt   = nug_pkg::ST_OUT;
          end
        end
      end
      nug_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {gain_im_r, gain_re_r};
          out_last_nxt  = last_r;
          state_nxt     = nug_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nug_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nug_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    power_r    <= power_nxt;
    err_re_r   <= err_re_nxt;
    err_im_r   <= err_im_nxt;
    last_r     <= last_nxt;
    comp_r     <= comp_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    gain_re_r  <= gain_re_nxt;
    gain_im_r  <= gain_im_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a bin without gain skips the divider entirely
  a_zero_gain_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !item_en) |=> (state_r == nug_pkg::ST_OUT))
    else $error("zero-gain bin did not go straight to output");

  // divider only reports back while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == nug_pkg::ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // a new result is only loaded from the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == nug_pkg::ST_OUT))
    else $error("result loaded outside the output state");

endmodule
